/* hdl/stepper_rate_ramp_pulse_generator_assert.svh */
// Assertion macros shared by the stepper rate ramp pulse generator modules.
`ifndef STEPPER_RATE_RAMP_PULSE_GENERATOR_ASSERT_SVH
`define STEPPER_RATE_RAMP_PULSE_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SRPG_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("srpg assertion failed");
`define SRPG_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("srpg assertion failed");
`else
`define SRPG_ASSERT_ALWAYS(lbl, cond)
`define SRPG_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* hdl/srpg_pkg.sv */
// Types and constants for the stepper rate ramp pulse generator.
package srpg_pkg;

  localparam int RateW  = 20;
  localparam int AccW   = 21;
  localparam int SlewW  = 16;
  localparam int ElapW  = 16;
  localparam int ProdW  = SlewW + ElapW;
  localparam int LimitW = ProdW - 8;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SLEW = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;

  localparam logic REG_TICK_RATE = 1'b0;
  localparam logic REG_SLEW_Q8   = 1'b1;

  localparam logic [RateW-1:0] TICK_RATE_RST = 20'd20000;
  localparam logic [SlewW-1:0] SLEW_Q8_RST   = 16'd256;

  typedef struct packed {
    logic [1:0]       op;
    logic [ElapW-1:0] elapsed_ms;
    logic [RateW-1:0] target_rate;
  } srpg_in_t;

  typedef struct packed {
    logic             step_out;
    logic [RateW-1:0] rate_now;
    logic             at_speed;
  } srpg_out_t;

  typedef struct packed {
    logic             we;
    logic             idx;
    logic [RateW-1:0] wdata;
  } srpg_cfg_t;

endpackage

/* hdl/srpg_core.sv */
// Step generator state, configuration registers and next-state logic.
`include "stepper_rate_ramp_pulse_generator_assert.svh"
module srpg_core
  import srpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  srpg_cfg_t cfg,
  input  logic      adv,
  input  srpg_in_t  item,
  output srpg_out_t res
);

  logic [RateW-1:0]  tick_rate_r;
  logic [SlewW-1:0]  slew_q8_r;
  logic [AccW-1:0]   phase_r, phase_nxt;
  logic              pulse_r, pulse_nxt;
  logic [RateW-1:0]  rate_r, rate_nxt;
  logic [RateW-1:0]  target_r, target_nxt;

  logic [AccW-1:0]   acc_sum;
  logic [AccW-1:0]   acc_sub;
  logic [ProdW-1:0]  prod;
  logic [LimitW-1:0] limit;
  logic              ramp_up;
  logic [RateW-1:0]  gap;
  logic [RateW-1:0]  step_amt;

  assign acc_sum  = phase_r + {1'b0, rate_r};
  assign acc_sub  = acc_sum - {1'b0, tick_rate_r};
  assign prod     = slew_q8_r * item.elapsed_ms;
  assign limit    = prod[ProdW-1:8];
  assign ramp_up  = rate_r < target_r;
  assign gap      = ramp_up ? (target_r - rate_r) : (rate_r - target_r);
  // The move is the smaller of the slew limit and the remaining gap.
  assign step_amt = (limit < {{(LimitW-RateW){1'b0}}, gap}) ? limit[RateW-1:0] : gap;

  always_comb begin
    phase_nxt  = phase_r;
    pulse_nxt  = pulse_r;
    rate_nxt   = rate_r;
    target_nxt = target_r;
    unique case (item.op)
      OP_TICK: begin
        if (pulse_r) begin
          pulse_nxt = 1'b0;
        end else if (rate_r != '0) begin
          if (acc_sum >= {1'b0, tick_rate_r}) begin
            phase_nxt = acc_sub;
            pulse_nxt = 1'b1;
          end else begin
            phase_nxt = acc_sum;
          end
        end
      end
      OP_SLEW: begin
        if (item.elapsed_ms != '0) begin
          rate_nxt = ramp_up ? (rate_r + step_amt) : (rate_r - step_amt);
        end
      end
      OP_SET: begin
        target_nxt = (item.target_rate < tick_rate_r) ? item.target_rate : tick_rate_r;
      end
      default: begin
      end
    endcase
  end

  assign res.step_out = pulse_nxt;
  assign res.rate_now = rate_nxt;
  assign res.at_speed = (target_nxt != '0) && (rate_nxt == target_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= TICK_RATE_RST;
      slew_q8_r   <= SLEW_Q8_RST;
      phase_r     <= '0;
      pulse_r     <= 1'b0;
      rate_r      <= '0;
      target_r    <= '0;
    end else begin
      if (cfg.we) begin
        unique case (cfg.idx)
          REG_TICK_RATE: tick_rate_r <= cfg.wdata;
          REG_SLEW_Q8:   slew_q8_r   <= cfg.wdata[SlewW-1:0];
          default: begin
          end
        endcase
      end
      if (adv) begin
        phase_r  <= phase_nxt;
        pulse_r  <= pulse_nxt;
        rate_r   <= rate_nxt;
        target_r <= target_nxt;
      end
    end
  end

  `SRPG_ASSERT_NEXT(a_pulse_one_tick, adv && (item.op == OP_TICK) && pulse_r, !pulse_r)
  `SRPG_ASSERT_NEXT(a_phase_tick_only, !(adv && (item.op == OP_TICK)), $stable(phase_r))
  `SRPG_ASSERT_NEXT(a_rate_slew_only, !(adv && (item.op == OP_SLEW)), $stable(rate_r))

endmodule

/* hdl/stepper_rate_ramp_pulse_generator.sv */
// Top level of the stepper rate ramp pulse generator: input and result registers.
// Each item is held in the input register, and its result then moves into the result register.
// Throughput: one item per cycle while the result register is not held; the core updates its state in a single pass.
// in_stall rises only when the input register is full and the result register is held.
// Reset clears both valid flags, the step state and the target, and loads
// tick_rate with 20000 and slew_q8 with 256.
`include "stepper_rate_ramp_pulse_generator_assert.svh"
module stepper_rate_ramp_pulse_generator
  import srpg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [RateW-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  srpg_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output srpg_out_t        out_data
);

  logic      s1_v_r, s1_v_nxt;
  srpg_in_t  s1_r;
  logic      out_v_r, out_v_nxt;
  srpg_out_t out_r;
  logic      adv;
  logic      in_take;
  srpg_cfg_t cfg;
  srpg_out_t res;

  assign cfg.we    = cfg_we;
  assign cfg.idx   = cfg_idx;
  assign cfg.wdata = cfg_wdata;

  // The held item moves into the result register when that register is free
  // or its result is being transferred out in this cycle.
  assign adv       = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall  = s1_v_r && !adv;
  assign in_take   = in_valid && !in_stall;
  assign s1_v_nxt  = in_take || (s1_v_r && !adv);
  assign out_v_nxt = adv || (out_v_r && out_stall);

  srpg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .adv   (adv),
    .item  (s1_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= in_data;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `SRPG_ASSERT_ALWAYS(a_stall_needs_item, !in_stall || s1_v_r)
  `SRPG_ASSERT_NEXT(a_adv_fills_out, adv, out_v_r)

endmodule

/* tb/stepper_rate_ramp_pulse_generator_tb.sv */
// Self-checking testbench for the stepper rate ramp pulse generator.
`timescale 1ns / 100ps
module stepper_rate_ramp_pulse_generator_tb;
  import srpg_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems = 230;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = REG_TICK_RATE;
  logic [RateW-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  srpg_in_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  srpg_out_t        out_data;

  // Predicted block state and register copies.
  logic [RateW-1:0] model_tick_rate = TICK_RATE_RST;
  logic [SlewW-1:0] model_slew = SLEW_Q8_RST;
  logic [AccW-1:0]  model_acc = '0;
  logic             model_pulse = 1'b0;
  logic [RateW-1:0] model_rate = '0;
  logic [RateW-1:0] model_target = '0;

  srpg_out_t expected_status[$];
  int        fail_count = 0;
  int        quiet_cycles = 0;
  bit        steady_flow = 1'b0;

  stepper_rate_ramp_pulse_generator DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  function automatic srpg_out_t predict_motion(input srpg_in_t item);
    logic [ProdW-1:0]  slew_prod;
    logic [LimitW-1:0] slew_limit;
    logic [RateW-1:0]  rate_gap;
    logic [RateW-1:0]  rate_move;
    srpg_out_t         status;
    case (item.op)
      OP_TICK: begin
        if (model_pulse) begin
          model_pulse = 1'b0;
        end else if (model_rate != '0) begin
          model_acc = model_acc + AccW'(model_rate);
          if (model_acc >= AccW'(model_tick_rate)) begin
            model_acc = model_acc - AccW'(model_tick_rate);
            model_pulse = 1'b1;
          end
        end
      end
      OP_SLEW: begin
        if (item.elapsed_ms != '0 && model_rate != model_target) begin
          slew_prod = ProdW'(model_slew) * ProdW'(item.elapsed_ms);
          slew_limit = slew_prod[ProdW-1:8];
          rate_gap = (model_rate < model_target) ? model_target - model_rate
                                                 : model_rate - model_target;
          rate_move = (slew_limit < LimitW'(rate_gap)) ? slew_limit[RateW-1:0] : rate_gap;
          if (model_rate < model_target) model_rate = model_rate + rate_move;
          else model_rate = model_rate - rate_move;
        end
      end
      OP_SET: begin
        model_target = (item.target_rate < model_tick_rate) ? item.target_rate
                                                            : model_tick_rate;
      end
      default: ;
    endcase
    status.step_out = model_pulse;
    status.rate_now = model_rate;
    status.at_speed = (model_target != '0) && (model_rate == model_target);
    return status;
  endfunction

  function automatic srpg_in_t motion_item(input logic [1:0] op, input logic [ElapW-1:0] ms,
                                           input logic [RateW-1:0] rate);
    srpg_in_t item;
    item.op = op;
    item.elapsed_ms = ms;
    item.target_rate = rate;
    return item;
  endfunction

  // Mostly ticks with slews and target changes mixed in, so the rate ramps and pulses.
  function automatic srpg_in_t random_motion_item();
    srpg_in_t    item;
    int unsigned pick;
    int unsigned sub;
    item.elapsed_ms = ElapW'($urandom);
    item.target_rate = RateW'($urandom);
    pick = $urandom_range(99);
    sub = $urandom_range(99);
    if (pick < 55) begin
      item.op = OP_TICK;
    end else if (pick < 75) begin
      item.op = OP_SLEW;
      if (sub < 10) item.elapsed_ms = '0;
      else if (sub < 70) item.elapsed_ms = ElapW'($urandom_range(1, 64));
    end else if (pick < 93) begin
      item.op = OP_SET;
      if (sub < 50) item.target_rate = RateW'($urandom_range(0, model_tick_rate));
      else if (sub < 60) item.target_rate = model_tick_rate;
      else if (sub < 68) item.target_rate = '0;
      else if (sub < 75) item.target_rate = '1;
    end else begin
      item.op = OP_UNUSED;
    end
    return item;
  endfunction

  task automatic send_item(input srpg_in_t item);
    if (!steady_flow) begin
      while ($urandom_range(99) < 38) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    expected_status.push_back(predict_motion(item));
  endtask

  // Leaves the block idle: no transfer pending and the pipeline drained.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [RateW-1:0] tick_val, input logic [RateW-1:0] slew_val);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= REG_TICK_RATE;
    cfg_wdata <= tick_val;
    @(posedge clk);
    cfg_idx <= REG_SLEW_Q8;
    cfg_wdata <= slew_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_tick_rate = tick_val;
    model_slew = slew_val[SlewW-1:0];
  endtask

  task automatic test_reset_defaults();
    send_item(motion_item(OP_UNUSED, '1, '1));
    send_item(motion_item(OP_TICK, '0, '0));
    send_item(motion_item(OP_SLEW, '0, '0));
    // The target saturates to the tick rate.
    send_item(motion_item(OP_SET, '0, '1));
    send_item(motion_item(OP_SLEW, 16'd1, '0));
    send_item(motion_item(OP_SLEW, '1, '0));
    repeat (3) send_item(motion_item(OP_TICK, '0, '0));
    send_item(motion_item(OP_SET, '1, '0));
    send_item(motion_item(OP_SLEW, '1, '1));
  endtask

  task automatic test_full_scale();
    // Upper write data bits beyond the slew register are dropped.
    program_regs('1, '1);
    send_item(motion_item(OP_SET, '0, '1));
    send_item(motion_item(OP_SLEW, '1, '0));
    repeat (3) send_item(motion_item(OP_TICK, '1, '1));
  endtask

  task automatic test_lowered_tick_rate();
    // The rate stays above the new tick rate and the slew is frozen.
    program_regs(20'd1000, '0);
    send_item(motion_item(OP_SLEW, 16'd40, '0));
    send_item(motion_item(OP_SET, '0, 20'd5000));
    repeat (3) send_item(motion_item(OP_TICK, '0, '0));
  endtask

  task automatic test_zero_tick_rate();
    program_regs('0, 20'd256);
    send_item(motion_item(OP_SET, '0, 20'd777));
    repeat (2) send_item(motion_item(OP_TICK, '0, '0));
    send_item(motion_item(OP_SLEW, '1, '0));
  endtask

  task automatic test_random_traffic(input logic [RateW-1:0] tick_val,
                                     input logic [RateW-1:0] slew_val, input bit no_gaps);
    program_regs(tick_val, slew_val);
    steady_flow = no_gaps;
    repeat (PhaseItems) send_item(random_motion_item());
    steady_flow = 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= steady_flow ? 1'b0 : ($urandom_range(99) < 38);
  end

  always @(posedge clk) begin
    srpg_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        fail_count++;
      end else begin
        want = expected_status.pop_front();
        if (out_data.step_out !== want.step_out) begin
          $error("step_out: expected %0d, got %0d", want.step_out, out_data.step_out);
          fail_count++;
        end
        if (out_data.rate_now !== want.rate_now) begin
          $error("rate_now: expected %0d, got %0d", want.rate_now, out_data.rate_now);
          fail_count++;
        end
        if (out_data.at_speed !== want.at_speed) begin
          $error("at_speed: expected %0d, got %0d", want.at_speed, out_data.at_speed);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_full_scale();
    test_lowered_tick_rate();
    test_zero_tick_rate();
    test_random_traffic(TICK_RATE_RST, 20'(SLEW_Q8_RST), 1'b0);
    test_random_traffic('1, 20'hFFFF, 1'b0);
    test_random_traffic(20'd1, 20'd1, 1'b0);
    test_random_traffic(20'd3000, 20'd40, 1'b1);
    test_random_traffic('0, 20'd512, 1'b0);
    test_random_traffic(20'd1000, '0, 1'b0);
    test_random_traffic(RateW'($urandom_range(1, 50000)), RateW'($urandom_range(0, 4096)), 1'b0);
    test_random_traffic(RateW'($urandom), RateW'($urandom), 1'b0);
    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
